// ----- hdl/fgn_pkg.sv -----
// ----------------------------------------------------------------------------
// fgn_pkg
// Shared types and constants of the fractal gradient noise core.
// ----------------------------------------------------------------------------
package fgn_pkg;

  localparam int MAX_OCTAVES = 4;
  localparam int TABLE_CELLS = 17;
  localparam int PIXEL_BITS  = 10;

  localparam int FRAC  = 16;
  localparam int ONE_Q = 1 << FRAC;
  localparam int PIX_W = 10;
  localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((64'd1 << PIXEL_BITS) - 64'd1);

  // gradient table split into banks by octave, row parity and column parity
  localparam int HALF_CELLS = (TABLE_CELLS + 1) / 2;
  localparam int BANK_DEPTH = HALF_CELLS * HALF_CELLS;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  localparam int OCT_W  = $clog2(MAX_OCTAVES + 1);
  localparam int POS_W  = PIX_W + FRAC + MAX_OCTAVES - 1;
  localparam int DX_W   = POS_W + 1;
  localparam int PROD_W = DX_W + 17;
  localparam int DOT_W  = PROD_W - 14;
  localparam int BX_W   = DOT_W + 1;
  localparam int BY_W   = BX_W + 1;
  localparam int SUM_W  = BY_W + $clog2(MAX_OCTAVES) + 1;
  localparam int TOT_W  = SUM_W + 16 - 8;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  localparam int ADDR_W    = 4;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_GRID_SHIFT   = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_OCTAVE_COUNT = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_CONTRAST     = REG_IDX_W'(2);

  typedef struct packed {
    logic              mode;
    logic [1:0]        octave_index;
    logic [4:0]        cell_row;
    logic [4:0]        cell_col;
    logic signed [15:0] gradient_x;
    logic signed [15:0] gradient_y;
    logic [9:0]        pixel_x;
    logic [9:0]        pixel_y;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] noise_value;
    logic [9:0]         out_x;
    logic [9:0]         out_y;
    logic               out_of_range;
  } out_beat_t;

  typedef struct packed {
    logic        en;
    logic [1:0]  oct;
    logic [4:0]  row;
    logic [4:0]  col;
    logic [31:0] data;
  } tbl_wr_t;

  typedef struct packed {
    logic             en;
    logic [PIX_W-1:0] cx;
    logic [PIX_W-1:0] cy;
  } tbl_rd_t;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic             oor;
    logic [OCT_W-1:0] nocts;
  } tag_t;

  typedef logic [MAX_OCTAVES-1:0][1:0][1:0][31:0] grad_set_t;

endpackage

// ----- hdl/fractal_gradient_noise_2d_core.sv -----
// ----------------------------------------------------------------------------
// fractal_gradient_noise_2d_core
// Fractal 2D gradient noise with a loadable gradient table.
// ----------------------------------------------------------------------------
//  Channel  | Signals                                  | Beat
//  src      | src_valid, src_stall, src_data           | gradient load or pixel
//  res      | res_valid, res_stall, res_data           | one noise result
//  cfg      | psel, penable, pwrite, paddr, pwdata ... | register access
//
//  One beat per cycle while src_stall is low. The 16 table banks (octave x row
//  parity x column parity) serve all four corners of every octave in one read.
//  A load beat writes one bank entry and gives no result. Reset is synchronous
//  and restores register defaults; table contents are undefined until loaded.
//  A stalled result holds while the stages behind it keep filling; src_stall
//  rises once every stage is full.
// ----------------------------------------------------------------------------
module fractal_gradient_noise_2d_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          src_valid,
  output logic                          src_stall,
  input  fgn_pkg::in_beat_t             src_data,
  output logic                          res_valid,
  input  logic                          res_stall,
  output fgn_pkg::out_beat_t            res_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fgn_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [3:0]         grid_shift;
  logic [2:0]         octave_count;
  logic signed [15:0] contrast;

  logic [fgn_pkg::REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[fgn_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_shift   <= 4'd7;
      octave_count <= 3'd1;
      contrast     <= 16'sd256;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        fgn_pkg::REG_GRID_SHIFT:   grid_shift   <= pwdata[3:0];
        fgn_pkg::REG_OCTAVE_COUNT: octave_count <= pwdata[2:0];
        fgn_pkg::REG_CONTRAST:     contrast     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      fgn_pkg::REG_GRID_SHIFT:   prdata = {28'b0, grid_shift};
      fgn_pkg::REG_OCTAVE_COUNT: prdata = {29'b0, octave_count};
      fgn_pkg::REG_CONTRAST:     prdata = {16'b0, contrast};
      default:                   prdata = '0;
    endcase
  end

  logic               dp_ready;
  logic               accept;
  logic               start;
  fgn_pkg::tbl_wr_t   wr;
  fgn_pkg::tbl_rd_t   rd;
  fgn_pkg::grad_set_t gset;

  assign src_stall = !dp_ready;
  assign accept    = src_valid && !src_stall;
  assign start     = accept && (src_data.mode == fgn_pkg::MODE_PIXEL);

  assign wr = '{en:   accept && (src_data.mode == fgn_pkg::MODE_LOAD)
                      && (int'(src_data.octave_index) < fgn_pkg::MAX_OCTAVES)
                      && (int'(src_data.cell_row) < fgn_pkg::TABLE_CELLS)
                      && (int'(src_data.cell_col) < fgn_pkg::TABLE_CELLS),
                oct:  src_data.octave_index,
                row:  src_data.cell_row,
                col:  src_data.cell_col,
                data: {src_data.gradient_y, src_data.gradient_x}};

  fgn_table u_table (
    .clk  (clk),
    .wr   (wr),
    .rd   (rd),
    .rdata(gset)
  );

  fgn_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .pix         (src_data),
    .grid_shift  (grid_shift),
    .octave_count(octave_count),
    .contrast    (contrast),
    .gset        (gset),
    .out_stall   (res_stall),
    .ready       (dp_ready),
    .rd          (rd),
    .out_valid   (res_valid),
    .out_beat    (res_data)
  );

endmodule

// ----- hdl/fgn_ram.sv -----
// ----------------------------------------------------------------------------
// fgn_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module fgn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 81
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/fgn_table.sv -----
// ----------------------------------------------------------------------------
// fgn_table
// Banked gradient table: one bank per octave and row/column parity, so the
// four corners of every octave are read together in one registered read.
// ----------------------------------------------------------------------------
module fgn_table (
  input  logic                clk,
  input  fgn_pkg::tbl_wr_t    wr,
  input  fgn_pkg::tbl_rd_t    rd,
  output fgn_pkg::grad_set_t  rdata
);

  logic [fgn_pkg::BANK_AW-1:0] waddr;

  assign waddr = fgn_pkg::BANK_AW'(int'(wr.row >> 1) * fgn_pkg::HALF_CELLS
                                  + int'(wr.col >> 1));

  for (genvar rp = 0; rp < 2; rp++) begin : g_row
    for (genvar cp = 0; cp < 2; cp++) begin : g_col
      logic [fgn_pkg::PIX_W:0]     rrow;
      logic [fgn_pkg::PIX_W:0]     rcol;
      logic [fgn_pkg::BANK_AW-1:0] raddr;

      assign rrow  = {1'b0, rd.cy} + (fgn_pkg::PIX_W + 1)'(rd.cy[0] ^ 1'(rp));
      assign rcol  = {1'b0, rd.cx} + (fgn_pkg::PIX_W + 1)'(rd.cx[0] ^ 1'(cp));
      assign raddr = fgn_pkg::BANK_AW'(int'(rrow >> 1) * fgn_pkg::HALF_CELLS
                                      + int'(rcol >> 1));

      for (genvar k = 0; k < fgn_pkg::MAX_OCTAVES; k++) begin : g_oct
        logic we;
        assign we = wr.en && (int'(wr.oct) == k) && (wr.row[0] == 1'(rp))
                    && (wr.col[0] == 1'(cp));

        fgn_ram #(
          .WIDTH(32),
          .DEPTH(fgn_pkg::BANK_DEPTH)
        ) u_bank (
          .clk  (clk),
          .we   (we),
          .waddr(waddr),
          .wdata(wr.data),
          .re   (rd.en),
          .raddr(raddr),
          .rdata(rdata[k][rp][cp])
        );
      end
    end
  end

endmodule

// ----- hdl/fgn_datapath.sv -----
// ----------------------------------------------------------------------------
// fgn_datapath
// Pixel pipeline: table read, corner dots, quintic fade, blends, octave sum,
// contrast gain and saturation. Each full stage holds while its successor cannot accept.
// ----------------------------------------------------------------------------
module fgn_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  fgn_pkg::in_beat_t         pix,
  input  logic [3:0]                grid_shift,
  input  logic [2:0]                octave_count,
  input  logic signed [15:0]        contrast,
  input  fgn_pkg::grad_set_t        gset,
  input  logic                      out_stall,
  output logic                      ready,
  output fgn_pkg::tbl_rd_t          rd,
  output logic                      out_valid,
  output fgn_pkg::out_beat_t        out_beat
);

  localparam int NST = 9;
  localparam int NO  = fgn_pkg::MAX_OCTAVES;
  localparam int PW  = fgn_pkg::PIX_W;

  logic [NST-1:0] vld;
  logic [NST-1:0] rdy;
  fgn_pkg::tag_t  tag [NST];
  fgn_pkg::tag_t  tag_in;

  // handshake chain
  always_comb begin
    rdy[NST-1] = !vld[NST-1] || !out_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= start;
      end
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      tag[0] <= tag_in;
    end
    for (int i = 1; i < NST; i++) begin
      if (rdy[i]) begin
        tag[i] <= tag[i-1];
      end
    end
  end

  // ---- accept: cell, weight, offsets, table read
  logic [PW-1:0]                px, py, cx, cy, lx, ly;
  logic [15:0]                  w_n [2];
  logic [fgn_pkg::POS_W-1:0]    dx_n [NO];
  logic [fgn_pkg::POS_W-1:0]    dy_n [NO];
  logic                         oor;
  logic [fgn_pkg::OCT_W-1:0]    nocts;

  always_comb begin
    px = pix.pixel_x & fgn_pkg::PIX_MASK;
    py = pix.pixel_y & fgn_pkg::PIX_MASK;
    cx = px >> grid_shift;
    cy = py >> grid_shift;
    lx = px & ~({PW{1'b1}} << grid_shift);
    ly = py & ~({PW{1'b1}} << grid_shift);
    w_n[0] = 16'({lx, {fgn_pkg::FRAC{1'b0}}} >> grid_shift);
    w_n[1] = 16'({ly, {fgn_pkg::FRAC{1'b0}}} >> grid_shift);
    oor = (int'(cx) + 1 >= fgn_pkg::TABLE_CELLS) || (int'(cy) + 1 >= fgn_pkg::TABLE_CELLS);
    for (int k = 0; k < NO; k++) begin
      dx_n[k] = ((fgn_pkg::POS_W'({px, {fgn_pkg::FRAC{1'b0}}}) << k) >> grid_shift)
                - fgn_pkg::POS_W'({cx, {fgn_pkg::FRAC{1'b0}}});
      dy_n[k] = ((fgn_pkg::POS_W'({py, {fgn_pkg::FRAC{1'b0}}}) << k) >> grid_shift)
                - fgn_pkg::POS_W'({cy, {fgn_pkg::FRAC{1'b0}}});
    end
    if (int'(octave_count) > NO) begin
      nocts = fgn_pkg::OCT_W'(NO);
    end else begin
      nocts = fgn_pkg::OCT_W'(octave_count);
    end
    tag_in = '{x: px, y: py, oor: oor, nocts: nocts};
    rd = '{en: start && !oor, cx: cx, cy: cy};
  end

  logic [15:0]               s0_w [2];
  logic [fgn_pkg::POS_W-1:0] s0_dx [NO];
  logic [fgn_pkg::POS_W-1:0] s0_dy [NO];
  logic                      s0_cx0, s0_cy0;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_w   <= w_n;
      s0_dx  <= dx_n;
      s0_dy  <= dy_n;
      s0_cx0 <= cx[0];
      s0_cy0 <= cy[0];
    end
  end

  // ---- corner dot products, fade first products
  logic signed [fgn_pkg::DOT_W-1:0] dot_n [NO][4];
  logic signed [37:0]               wt_n [2];
  logic [31:0]                      ww_n [2];

  always_comb begin
    logic [31:0]                       e;
    logic signed [15:0]                gx, gy;
    logic signed [fgn_pkg::DX_W-1:0]   dxs, dys;
    logic signed [fgn_pkg::PROD_W-1:0] pr;
    logic signed [21:0]                ws, t;
    logic signed [37:0]                a38, b38;
    for (int k = 0; k < NO; k++) begin
      for (int c = 0; c < 4; c++) begin
        e   = gset[k][s0_cy0 ^ 1'(c >> 1)][s0_cx0 ^ 1'(c & 1)];
        gx  = e[15:0];
        gy  = e[31:16];
        dxs = $signed({1'b0, s0_dx[k]});
        dys = $signed({1'b0, s0_dy[k]});
        if ((c & 1) != 0) begin
          dxs = dxs - fgn_pkg::DX_W'(fgn_pkg::ONE_Q);
        end
        if ((c >> 1) != 0) begin
          dys = dys - fgn_pkg::DX_W'(fgn_pkg::ONE_Q);
        end
        pr = dxs * gx + dys * gy;
        dot_n[k][c] = fgn_pkg::DOT_W'(pr >>> 14);
      end
    end
    for (int d = 0; d < 2; d++) begin
      ws  = $signed({6'b0, s0_w[d]});
      t   = ws * 22'sd6 - 22'sd983040;
      a38 = ws;
      b38 = t;
      wt_n[d] = a38 * b38;
      ww_n[d] = s0_w[d] * s0_w[d];
    end
  end

  logic signed [fgn_pkg::DOT_W-1:0] s1_dot [NO][4];
  logic signed [37:0]               s1_wt [2];
  logic [31:0]                      s1_ww [2];
  logic [15:0]                      s1_w [2];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_dot <= dot_n;
      s1_wt  <= wt_n;
      s1_ww  <= ww_n;
      s1_w   <= s0_w;
    end
  end

  // ---- fade middle terms
  logic signed [21:0] p_n [2];
  logic [31:0]        w3m_n [2];

  always_comb begin
    for (int d = 0; d < 2; d++) begin
      p_n[d]   = 22'(s1_wt[d] >>> 16) + 22'sd655360;
      w3m_n[d] = s1_ww[d][31:16] * s1_w[d];
    end
  end

  logic signed [fgn_pkg::DOT_W-1:0] s2_dot [NO][4];
  logic signed [21:0]               s2_p [2];
  logic [31:0]                      s2_w3m [2];

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_dot <= s1_dot;
      s2_p   <= p_n;
      s2_w3m <= w3m_n;
    end
  end

  // ---- fade result
  logic [16:0] f_n [2];

  always_comb begin
    logic signed [38:0] a39, b39, fp;
    for (int d = 0; d < 2; d++) begin
      a39 = $signed({1'b0, s2_w3m[d][31:16]});
      b39 = s2_p[d];
      fp  = a39 * b39;
      f_n[d] = fp[32:16];
    end
  end

  logic signed [fgn_pkg::DOT_W-1:0] s3_dot [NO][4];
  logic [16:0]                      s3_f [2];

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_dot <= s2_dot;
      s3_f   <= f_n;
    end
  end

  // ---- blend along x
  localparam int MX_W = fgn_pkg::BX_W + 18;

  logic signed [fgn_pkg::BX_W-1:0] top_n [NO];
  logic signed [fgn_pkg::BX_W-1:0] bot_n [NO];

  always_comb begin
    logic signed [MX_W-1:0] a, b, m, f, s;
    for (int k = 0; k < NO; k++) begin
      f = $signed({1'b0, s3_f[0]});
      a = s3_dot[k][0];
      b = s3_dot[k][1];
      m = (b - a) * f;
      s = a + (m >>> 16);
      top_n[k] = s[fgn_pkg::BX_W-1:0];
      a = s3_dot[k][2];
      b = s3_dot[k][3];
      m = (b - a) * f;
      s = a + (m >>> 16);
      bot_n[k] = s[fgn_pkg::BX_W-1:0];
    end
  end

  logic signed [fgn_pkg::BX_W-1:0] s4_top [NO];
  logic signed [fgn_pkg::BX_W-1:0] s4_bot [NO];
  logic [16:0]                     s4_fy;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_top <= top_n;
      s4_bot <= bot_n;
      s4_fy  <= s3_f[1];
    end
  end

  // ---- blend along y
  localparam int MY_W = fgn_pkg::BY_W + 18;

  logic signed [fgn_pkg::BY_W-1:0] res_n [NO];

  always_comb begin
    logic signed [MY_W-1:0] a, b, m, f, s;
    for (int k = 0; k < NO; k++) begin
      f = $signed({1'b0, s4_fy});
      a = s4_top[k];
      b = s4_bot[k];
      m = (b - a) * f;
      s = a + (m >>> 16);
      res_n[k] = s[fgn_pkg::BY_W-1:0];
    end
  end

  logic signed [fgn_pkg::BY_W-1:0] s5_res [NO];

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_res <= res_n;
    end
  end

  // ---- octave sum
  logic signed [fgn_pkg::SUM_W-1:0] sum_n;

  always_comb begin
    logic signed [fgn_pkg::SUM_W-1:0] term;
    sum_n = '0;
    for (int k = 0; k < NO; k++) begin
      term = s5_res[k];
      term = term >>> (3 * k);
      if (k < int'(tag[5].nocts)) begin
        sum_n = sum_n + term;
      end
    end
  end

  logic signed [fgn_pkg::SUM_W-1:0] s6_sum;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_sum <= sum_n;
    end
  end

  // ---- contrast gain
  localparam int GP_W = fgn_pkg::SUM_W + 16;

  logic signed [fgn_pkg::TOT_W-1:0] tot_n;

  always_comb begin
    logic signed [GP_W-1:0] a, b, m;
    a = s6_sum;
    b = contrast;
    m = a * b;
    tot_n = fgn_pkg::TOT_W'(m >>> 8);
  end

  logic signed [fgn_pkg::TOT_W-1:0] s7_tot;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s7_tot <= tot_n;
    end
  end

  // ---- saturation and result register
  logic signed [31:0] noise_n;
  logic [fgn_pkg::TOT_W-32:0] hi;

  always_comb begin
    hi = s7_tot[fgn_pkg::TOT_W-1:31];
    if (tag[7].oor) begin
      noise_n = '0;
    end else if ((hi == '0) || (hi == '1)) begin
      noise_n = s7_tot[31:0];
    end else if (s7_tot[fgn_pkg::TOT_W-1]) begin
      noise_n = 32'sh8000_0000;
    end else begin
      noise_n = 32'sh7FFF_FFFF;
    end
  end

  logic signed [31:0] s8_noise;

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      s8_noise <= noise_n;
    end
  end

  assign out_valid = vld[NST-1];
  assign out_beat  = '{noise_value: s8_noise, out_x: tag[NST-1].x, out_y: tag[NST-1].y,
                       out_of_range: tag[NST-1].oor};

endmodule

// ----- hdl/fgn_checker.sv -----
// ----------------------------------------------------------------------------
// fgn_checker
// Port-level checks of the noise core, bound to the top level.
// ----------------------------------------------------------------------------
module fgn_checker (
  input logic               clk,
  input logic               rst,
  input logic               src_stall,
  input logic               res_valid,
  input logic               res_stall,
  input fgn_pkg::out_beat_t res_data
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("result beat dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> $stable(res_data))
    else $error("stalled result changed");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.out_of_range |-> res_data.noise_value == 32'sd0)
    else $error("out of range pixel with nonzero noise");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !src_stall)
    else $error("input stalled with no result pending");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result present after reset");

endmodule

bind fractal_gradient_noise_2d_core fgn_checker u_fgn_checker (.*);
